/* hdl/byte_alu_znhc_flags_defines.svh */
// Assertion macros shared by the byte ALU RTL.
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef BYTE_ALU_ZNHC_FLAGS_DEFINES_SVH
`define BYTE_ALU_ZNHC_FLAGS_DEFINES_SVH
`ifndef ASSERT_OFF
// Check sampled on clk_i, disabled while rst_ni is low.
`define BZF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Check sampled on clk_i at every edge, reset included.
`define BZF_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define BZF_ASSERT(lbl, prop, msg)
`define BZF_ASSERT_RST(lbl, prop, msg)
`endif
`endif

/* hdl/bzf_pkg.sv */
// Types and constants for the byte ALU with Z N H C flags.
// No dependencies; used by bzf_alu and byte_alu_znhc_flags.
`default_nettype none
package bzf_pkg;

  typedef enum logic [5:0] {
    OP_ADD        = 6'd0,
    OP_ADC        = 6'd1,
    OP_SUB        = 6'd2,
    OP_SBC        = 6'd3,
    OP_AND        = 6'd4,
    OP_XOR        = 6'd5,
    OP_OR         = 6'd6,
    OP_CP         = 6'd7,
    OP_INC        = 6'd8,
    OP_DEC        = 6'd9,
    OP_DAA        = 6'd10,
    OP_CPL        = 6'd11,
    OP_SCF        = 6'd12,
    OP_CCF        = 6'd13,
    OP_RLCA       = 6'd14,
    OP_RRCA       = 6'd15,
    OP_RLA        = 6'd16,
    OP_RRA        = 6'd17,
    OP_RLC        = 6'd18,
    OP_RRC        = 6'd19,
    OP_RL         = 6'd20,
    OP_RR         = 6'd21,
    OP_SLA        = 6'd22,
    OP_SRA        = 6'd23,
    OP_SRL        = 6'd24,
    OP_SWAP       = 6'd25,
    OP_BIT        = 6'd26,
    OP_SET        = 6'd27,
    OP_RES        = 6'd28,
    OP_ADD_HL     = 6'd29,
    OP_ADD_SP     = 6'd30,
    OP_LOAD_A     = 6'd31,
    OP_LOAD_FLAGS = 6'd32
  } op_e;

  // Z in bit 3 down to C in bit 0
  typedef struct packed {
    logic z;
    logic n;
    logic h;
    logic c;
  } flags_t;

  typedef struct packed {
    op_e         cmd;
    logic [15:0] operand;
    logic [2:0]  bit_index;
    logic [15:0] base_word;
  } alu_req_t;

  typedef struct packed {
    logic [15:0] value_out;
    logic [7:0]  accumulator_out;
    flags_t      flags_out;
  } alu_rsp_t;

  localparam int unsigned CMD_W       = 6;
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 32;

  localparam logic [7:0] ACC_RESET   = 8'h01;
  localparam flags_t     FLAGS_RESET = '{z: 1'b1, n: 1'b0, h: 1'b1, c: 1'b1};

  localparam logic [7:0] DAA_LIMIT     = 8'h99;
  localparam logic [3:0] DAA_NIB_LIMIT = 4'h9;
  localparam logic [7:0] DAA_HI_ADJ    = 8'h60;
  localparam logic [7:0] DAA_LO_ADJ    = 8'h06;

endpackage
`default_nettype wire

/* hdl/bzf_alu.sv */
// Combinational datapath of the byte ALU: one operation against acc/flags.
// Depends on bzf_pkg.
`default_nettype none
module bzf_alu (
  input  bzf_pkg::alu_req_t req_i,
  input  logic [7:0]        acc_i,
  input  bzf_pkg::flags_t   flags_i,
  output bzf_pkg::alu_rsp_t rsp_o
);

  logic [7:0]  v;
  logic [15:0] opw;
  logic [15:0] base;
  logic        is_sub;
  logic        cin;
  logic [8:0]  sum9;
  logic        arith_h;
  logic [7:0]  inc_r;
  logic [7:0]  dec_r;
  logic [7:0]  logic_and;
  logic [7:0]  logic_xor;
  logic [7:0]  logic_or;
  logic [7:0]  daa_a;
  logic        daa_c;
  logic [7:0]  daa_hi;
  logic [7:0]  bit_mask;
  logic [16:0] hl_sum;
  logic [12:0] hl_low;
  logic [15:0] sp_sum;
  logic [8:0]  sp_lo;
  logic [4:0]  sp_nib;
  logic [7:0]  sh_r;
  logic        sh_c;

  assign v    = req_i.operand[7:0];
  assign opw  = req_i.operand;
  assign base = req_i.base_word;

  // shared 9-bit adder for add/adc/sub/sbc/cp
  assign is_sub  = (req_i.cmd == bzf_pkg::OP_SUB) || (req_i.cmd == bzf_pkg::OP_SBC) ||
                   (req_i.cmd == bzf_pkg::OP_CP);
  assign cin     = ((req_i.cmd == bzf_pkg::OP_ADC) || (req_i.cmd == bzf_pkg::OP_SBC)) ?
                   flags_i.c : 1'b0;
  assign sum9    = is_sub ? ({1'b0, acc_i} - {1'b0, v} - {8'd0, cin})
                          : ({1'b0, acc_i} + {1'b0, v} + {8'd0, cin});
  assign arith_h = sum9[4] ^ acc_i[4] ^ v[4];

  assign inc_r     = v + 8'd1;
  assign dec_r     = v - 8'd1;
  assign logic_and = acc_i & v;
  assign logic_xor = acc_i ^ v;
  assign logic_or  = acc_i | v;
  assign bit_mask  = 8'd1 << req_i.bit_index;

  assign hl_sum = {1'b0, base} + {1'b0, opw};
  assign hl_low = {1'b0, base[11:0]} + {1'b0, opw[11:0]};
  assign sp_sum = base + {{8{v[7]}}, v};
  assign sp_lo  = {1'b0, base[7:0]} + {1'b0, v};
  assign sp_nib = {1'b0, base[3:0]} + {1'b0, v[3:0]};

  // decimal adjust
  always_comb begin
    daa_hi = acc_i;
    daa_c  = flags_i.c;
    if (flags_i.n) begin
      if (flags_i.c) daa_hi = acc_i - bzf_pkg::DAA_HI_ADJ;
      daa_a = flags_i.h ? (daa_hi - bzf_pkg::DAA_LO_ADJ) : daa_hi;
    end else begin
      if ((acc_i > bzf_pkg::DAA_LIMIT) || flags_i.c) begin
        daa_hi = acc_i + bzf_pkg::DAA_HI_ADJ;
        daa_c  = 1'b1;
      end
      daa_a = ((daa_hi[3:0] > bzf_pkg::DAA_NIB_LIMIT) || flags_i.h) ?
              (daa_hi + bzf_pkg::DAA_LO_ADJ) : daa_hi;
    end
  end

  // prefixed rotates and shifts on the operand byte
  always_comb begin
    sh_r = v;
    sh_c = 1'b0;
    unique case (req_i.cmd)
      bzf_pkg::OP_RLC:  begin sh_r = {v[6:0], v[7]};      sh_c = v[7]; end
      bzf_pkg::OP_RRC:  begin sh_r = {v[0], v[7:1]};      sh_c = v[0]; end
      bzf_pkg::OP_RL:   begin sh_r = {v[6:0], flags_i.c}; sh_c = v[7]; end
      bzf_pkg::OP_RR:   begin sh_r = {flags_i.c, v[7:1]}; sh_c = v[0]; end
      bzf_pkg::OP_SLA:  begin sh_r = {v[6:0], 1'b0};      sh_c = v[7]; end
      bzf_pkg::OP_SRA:  begin sh_r = {v[7], v[7:1]};      sh_c = v[0]; end
      bzf_pkg::OP_SRL:  begin sh_r = {1'b0, v[7:1]};      sh_c = v[0]; end
      bzf_pkg::OP_SWAP: begin sh_r = {v[3:0], v[7:4]};    sh_c = 1'b0; end
      default:          begin sh_r = v;                   sh_c = 1'b0; end
    endcase
  end

  always_comb begin
    rsp_o.value_out       = 16'd0;
    rsp_o.accumulator_out = acc_i;
    rsp_o.flags_out       = flags_i;
    unique case (req_i.cmd)
      bzf_pkg::OP_ADD, bzf_pkg::OP_ADC, bzf_pkg::OP_SUB, bzf_pkg::OP_SBC: begin
        rsp_o.accumulator_out = sum9[7:0];
        rsp_o.flags_out = '{z: (sum9[7:0] == 8'd0), n: is_sub, h: arith_h, c: sum9[8]};
      end
      bzf_pkg::OP_CP: begin
        rsp_o.flags_out = '{z: (sum9[7:0] == 8'd0), n: 1'b1, h: arith_h, c: sum9[8]};
      end
      bzf_pkg::OP_AND: begin
        rsp_o.accumulator_out = logic_and;
        rsp_o.flags_out = '{z: (logic_and == 8'd0), n: 1'b0, h: 1'b1, c: 1'b0};
      end
      bzf_pkg::OP_XOR: begin
        rsp_o.accumulator_out = logic_xor;
        rsp_o.flags_out = '{z: (logic_xor == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
      end
      bzf_pkg::OP_OR: begin
        rsp_o.accumulator_out = logic_or;
        rsp_o.flags_out = '{z: (logic_or == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
      end
      bzf_pkg::OP_INC: begin
        rsp_o.value_out = {8'd0, inc_r};
        rsp_o.flags_out = '{z: (inc_r == 8'd0), n: 1'b0, h: (inc_r[3:0] == 4'h0),
                            c: flags_i.c};
      end
      bzf_pkg::OP_DEC: begin
        rsp_o.value_out = {8'd0, dec_r};
        rsp_o.flags_out = '{z: (dec_r == 8'd0), n: 1'b1, h: (dec_r[3:0] == 4'hf),
                            c: flags_i.c};
      end
      bzf_pkg::OP_DAA: begin
        rsp_o.accumulator_out = daa_a;
        rsp_o.flags_out = '{z: (daa_a == 8'd0), n: flags_i.n, h: 1'b0, c: daa_c};
      end
      bzf_pkg::OP_CPL: begin
        rsp_o.accumulator_out = ~acc_i;
        rsp_o.flags_out = '{z: flags_i.z, n: 1'b1, h: 1'b1, c: flags_i.c};
      end
      bzf_pkg::OP_SCF: begin
        rsp_o.flags_out = '{z: flags_i.z, n: 1'b0, h: 1'b0, c: 1'b1};
      end
      bzf_pkg::OP_CCF: begin
        rsp_o.flags_out = '{z: flags_i.z, n: 1'b0, h: 1'b0, c: ~flags_i.c};
      end
      bzf_pkg::OP_RLCA: begin
        rsp_o.accumulator_out = {acc_i[6:0], acc_i[7]};
        rsp_o.flags_out = '{z: 1'b0, n: 1'b0, h: 1'b0, c: acc_i[7]};
      end
      bzf_pkg::OP_RRCA: begin
        rsp_o.accumulator_out = {acc_i[0], acc_i[7:1]};
        rsp_o.flags_out = '{z: 1'b0, n: 1'b0, h: 1'b0, c: acc_i[0]};
      end
      bzf_pkg::OP_RLA: begin
        rsp_o.accumulator_out = {acc_i[6:0], flags_i.c};
        rsp_o.flags_out = '{z: 1'b0, n: 1'b0, h: 1'b0, c: acc_i[7]};
      end
      bzf_pkg::OP_RRA: begin
        rsp_o.accumulator_out = {flags_i.c, acc_i[7:1]};
        rsp_o.flags_out = '{z: 1'b0, n: 1'b0, h: 1'b0, c: acc_i[0]};
      end
      bzf_pkg::OP_RLC, bzf_pkg::OP_RRC, bzf_pkg::OP_RL, bzf_pkg::OP_RR,
      bzf_pkg::OP_SLA, bzf_pkg::OP_SRA, bzf_pkg::OP_SRL, bzf_pkg::OP_SWAP: begin
        rsp_o.value_out = {8'd0, sh_r};
        rsp_o.flags_out = '{z: (sh_r == 8'd0), n: 1'b0, h: 1'b0, c: sh_c};
      end
      bzf_pkg::OP_BIT: begin
        rsp_o.flags_out = '{z: ((v & bit_mask) == 8'd0), n: 1'b0, h: 1'b1, c: flags_i.c};
      end
      bzf_pkg::OP_SET: begin
        rsp_o.value_out = {8'd0, v | bit_mask};
      end
      bzf_pkg::OP_RES: begin
        rsp_o.value_out = {8'd0, v & ~bit_mask};
      end
      bzf_pkg::OP_ADD_HL: begin
        rsp_o.value_out = hl_sum[15:0];
        rsp_o.flags_out = '{z: flags_i.z, n: 1'b0, h: hl_low[12], c: hl_sum[16]};
      end
      bzf_pkg::OP_ADD_SP: begin
        rsp_o.value_out = sp_sum;
        rsp_o.flags_out = '{z: 1'b0, n: 1'b0, h: sp_nib[4], c: sp_lo[8]};
      end
      bzf_pkg::OP_LOAD_A: begin
        rsp_o.accumulator_out = v;
      end
      bzf_pkg::OP_LOAD_FLAGS: begin
        rsp_o.flags_out = bzf_pkg::flags_t'(opw[3:0]);
      end
      default: begin
        // unused codes: no operation
        rsp_o.value_out = 16'd0;
      end
    endcase
  end

endmodule
`default_nettype wire

/* hdl/byte_alu_znhc_flags.sv */
// Top level of the byte ALU: stream ports, input/result registers, acc/flag state.
// Depends on bzf_pkg, bzf_alu and byte_alu_znhc_flags_defines.svh.
//
// Usage
//   Slave stream (s_*): one ALU operation per transaction. tuser carries the
//   operation code, tdata carries operand, bit index and the 16-bit base.
//   Master stream (m_*): one result transaction per operation, in order:
//   operand-type value, accumulator and flags after the operation.
//   Flow: an operation accepted on the slave stream is latched in the input
//   register, evaluated against the accumulator and flags, and loaded into the
//   result register when that register can take a new result, which raises
//   m_tvalid_o.
//   Throughput: one transaction per cycle unless m_tready_i stalls the result.
//   The accumulator and flags are written in the same edge that loads the result
//   register, so back-to-back operations see each other's effect with no bubble.
//   Reset: valid bits cleared, accumulator = 0x01, flags = Z H C set, N clear.
//   Stall: while a result waits on m_tready_i, the input register keeps one
//   more operation and s_tready_o stays high until it is full; state advances
//   only when the held operation can move into the result register.
`default_nettype none
`include "byte_alu_znhc_flags_defines.svh"
module byte_alu_znhc_flags (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // slave side
  input  logic                                 s_tvalid_i,
  output logic                                 s_tready_o,
  // [15:0] operand, [18:16] bit_index, [34:19] base_word, [39:35] zero
  input  logic [bzf_pkg::IN_TDATA_W-1:0]       s_tdata_i,
  // [5:0] cmd
  input  logic [bzf_pkg::CMD_W-1:0]            s_tuser_i,
  // master side
  output logic                                 m_tvalid_o,
  input  logic                                 m_tready_i,
  // [15:0] value_out, [23:16] accumulator_out, [27:24] flags_out (Z N H C), [31:28] zero
  output logic [bzf_pkg::OUT_TDATA_W-1:0]      m_tdata_o
);

  bzf_pkg::alu_req_t req_q;
  logic              req_vld_q;
  bzf_pkg::alu_rsp_t rsp_q;
  logic              rsp_vld_q;
  logic [7:0]        acc_q;
  bzf_pkg::flags_t   flags_q;

  bzf_pkg::alu_req_t req_d;
  bzf_pkg::alu_rsp_t rsp_d;
  logic              req_vld_d;
  logic              rsp_vld_d;

  logic advance;  // result register can take a new result
  logic step;     // held operation executes this cycle
  logic in_fire;

  logic out_stall;     // result waiting on a stalled receiver
  logic rsp_in_sync;   // result register agrees with acc/flags
  logic at_reset_val;  // acc/flags at reset values, no result shown

  assign advance    = !rsp_vld_q || m_tready_i;
  assign step       = req_vld_q && advance;
  assign s_tready_o = !req_vld_q || advance;
  assign in_fire    = s_tvalid_i && s_tready_o;

  assign req_d.cmd       = bzf_pkg::op_e'(s_tuser_i);
  assign req_d.operand   = s_tdata_i[15:0];
  assign req_d.bit_index = s_tdata_i[18:16];
  assign req_d.base_word = s_tdata_i[34:19];

  always_comb begin
    if (in_fire) begin
      req_vld_d = 1'b1;
    end else if (step) begin
      req_vld_d = 1'b0;
    end else begin
      req_vld_d = req_vld_q;
    end
    if (step) begin
      rsp_vld_d = 1'b1;
    end else if (m_tready_i) begin
      rsp_vld_d = 1'b0;
    end else begin
      rsp_vld_d = rsp_vld_q;
    end
  end

  bzf_alu u_alu (
    .req_i   (req_q),
    .acc_i   (acc_q),
    .flags_i (flags_q),
    .rsp_o   (rsp_d)
  );

  // control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_vld_q <= 1'b0;
      rsp_vld_q <= 1'b0;
      acc_q     <= bzf_pkg::ACC_RESET;
      flags_q   <= bzf_pkg::FLAGS_RESET;
    end else begin
      req_vld_q <= req_vld_d;
      rsp_vld_q <= rsp_vld_d;
      if (step) begin
        acc_q   <= rsp_d.accumulator_out;
        flags_q <= rsp_d.flags_out;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      req_q <= req_d;
    end
    if (step) begin
      rsp_q <= rsp_d;
    end
  end

  assign m_tvalid_o = rsp_vld_q;
  assign m_tdata_o  = {4'd0, rsp_q.flags_out, rsp_q.accumulator_out, rsp_q.value_out};

  assign out_stall    = m_tvalid_o && !m_tready_i;
  assign rsp_in_sync  = (rsp_q.accumulator_out == acc_q) && (rsp_q.flags_out == flags_q);
  assign at_reset_val = (acc_q == bzf_pkg::ACC_RESET) && (flags_q == bzf_pkg::FLAGS_RESET) &&
                        !m_tvalid_o;

  // state must not move while the result register is blocked
  `BZF_ASSERT(a_state_hold_on_stall, out_stall |=> $stable({acc_q, flags_q}), "acc/flags moved")
  // a shown result always carries the current architectural state
  `BZF_ASSERT(a_rsp_matches_state, m_tvalid_o |-> rsp_in_sync, "result out of sync with state")
  // an executed operation produces a result on the next cycle
  `BZF_ASSERT(a_step_gives_rsp, step |=> m_tvalid_o, "executed operation lost")
  // reset values loaded by the edge after reset is seen
  `BZF_ASSERT_RST(a_reset_state, !rst_ni |=> at_reset_val, "wrong state during reset")

endmodule
`default_nettype wire

/* dv/byte_alu_znhc_flags_tb.sv */
// Self-checking testbench for byte_alu_znhc_flags: drives ALU operations on the slave stream
// and checks every result against a shadow acc/flag predictor or a hand-written expectation.
// Depends on bzf_pkg and the byte_alu_znhc_flags RTL.
`timescale 1ns / 1ps
module byte_alu_znhc_flags_tb;

  localparam int unsigned RANDOM_OPS = 750;
  localparam int unsigned PHASE_LEN  = RANDOM_OPS / 3;
  localparam int unsigned CYCLE_CAP  = 200000;
  localparam int unsigned DRAIN_CYC  = 8;

  // opcodes outside the decoded range; the ALU treats them as no-ops
  localparam logic [5:0] CMD_UNUSED_LO = 6'd33;
  localparam logic [5:0] CMD_UNUSED_HI = 6'd63;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            s_tvalid_i = 1'b0;
  logic                            s_tready_o;
  logic [bzf_pkg::IN_TDATA_W-1:0]  s_tdata_i = '0;
  logic [bzf_pkg::CMD_W-1:0]       s_tuser_i = '0;
  logic                            m_tvalid_o;
  logic                            m_tready_i = 1'b0;
  logic [bzf_pkg::OUT_TDATA_W-1:0] m_tdata_o;

  always #6 clk_i = ~clk_i;

  byte_alu_znhc_flags uut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_tvalid_i(s_tvalid_i),
    .s_tready_o(s_tready_o),
    .s_tdata_i (s_tdata_i),
    .s_tuser_i (s_tuser_i),
    .m_tvalid_o(m_tvalid_o),
    .m_tready_i(m_tready_i),
    .m_tdata_o (m_tdata_o)
  );

  // shadow architectural state
  logic [7:0]      acc_shadow   = bzf_pkg::ACC_RESET;
  bzf_pkg::flags_t flags_shadow = bzf_pkg::FLAGS_RESET;

  bzf_pkg::alu_rsp_t pending_results[$];
  int unsigned error_count   = 0;
  int unsigned results_seen  = 0;
  int unsigned ops_issued    = 0;
  int unsigned unused_issued = 0;
  int unsigned cycle_count   = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  logic [63:0] opcodes_hit   = '0;

  // Predict one operation and advance the shadow accumulator and flags.
  function automatic bzf_pkg::alu_rsp_t compute_alu_result(input logic [5:0] cmd,
                                                           input logic [15:0] opw,
                                                           input logic [2:0] bi,
                                                           input logic [15:0] base);
    logic [7:0]        a;
    logic [7:0]        v;
    logic [7:0]        r8;
    logic              co;
    logic              cin;
    logic              sub;
    logic              cy;
    logic [8:0]        s9;
    logic [16:0]       s17;
    logic [12:0]       h12;
    logic [4:0]        h4;
    logic [8:0]        c8;
    logic [15:0]       val;
    bzf_pkg::flags_t   f;
    bzf_pkg::alu_rsp_t r;
    a   = acc_shadow;
    v   = opw[7:0];
    f   = flags_shadow;
    cy  = f.c;
    val = '0;
    case (cmd)
      bzf_pkg::OP_ADD, bzf_pkg::OP_ADC, bzf_pkg::OP_SUB, bzf_pkg::OP_SBC,
      bzf_pkg::OP_CP: begin
        cin = (cmd == bzf_pkg::OP_ADC || cmd == bzf_pkg::OP_SBC) ? cy : 1'b0;
        sub = (cmd == bzf_pkg::OP_SUB || cmd == bzf_pkg::OP_SBC || cmd == bzf_pkg::OP_CP);
        s9  = sub ? ({1'b0, a} - {1'b0, v} - {8'd0, cin})
                  : ({1'b0, a} + {1'b0, v} + {8'd0, cin});
        f.z = (s9[7:0] == 8'd0);
        f.n = sub;
        f.h = s9[4] ^ a[4] ^ v[4];   // carry/borrow out of bit 3
        f.c = s9[8];
        if (cmd != bzf_pkg::OP_CP) a = s9[7:0];
      end
      bzf_pkg::OP_AND: begin
        a = a & v; f = '0; f.z = (a == 8'd0); f.h = 1'b1;
      end
      bzf_pkg::OP_XOR: begin
        a = a ^ v; f = '0; f.z = (a == 8'd0);
      end
      bzf_pkg::OP_OR: begin
        a = a | v; f = '0; f.z = (a == 8'd0);
      end
      bzf_pkg::OP_INC: begin
        r8 = v + 8'd1; val = {8'd0, r8};
        f.z = (r8 == 8'd0); f.n = 1'b0; f.h = (r8[3:0] == 4'h0);
      end
      bzf_pkg::OP_DEC: begin
        r8 = v - 8'd1; val = {8'd0, r8};
        f.z = (r8 == 8'd0); f.n = 1'b1; f.h = (r8[3:0] == 4'hf);
      end
      bzf_pkg::OP_DAA: begin
        if (f.n) begin
          if (f.c) a = a - 8'h60;
          if (f.h) a = a - 8'h06;
        end else begin
          if (a > 8'h99 || f.c) begin
            a = a + 8'h60; f.c = 1'b1;
          end
          if (a[3:0] > 4'd9 || f.h) a = a + 8'h06;
        end
        f.z = (a == 8'd0); f.h = 1'b0;
      end
      bzf_pkg::OP_CPL: begin
        a = ~a; f.n = 1'b1; f.h = 1'b1;
      end
      bzf_pkg::OP_SCF: begin
        f.n = 1'b0; f.h = 1'b0; f.c = 1'b1;
      end
      bzf_pkg::OP_CCF: begin
        f.n = 1'b0; f.h = 1'b0; f.c = ~cy;
      end
      // accumulator rotates: only C survives
      bzf_pkg::OP_RLCA: begin
        f = '0; f.c = a[7]; a = {a[6:0], a[7]};
      end
      bzf_pkg::OP_RRCA: begin
        f = '0; f.c = a[0]; a = {a[0], a[7:1]};
      end
      bzf_pkg::OP_RLA: begin
        f = '0; f.c = a[7]; a = {a[6:0], cy};
      end
      bzf_pkg::OP_RRA: begin
        f = '0; f.c = a[0]; a = {cy, a[7:1]};
      end
      bzf_pkg::OP_RLC, bzf_pkg::OP_RRC, bzf_pkg::OP_RL, bzf_pkg::OP_RR,
      bzf_pkg::OP_SLA, bzf_pkg::OP_SRA, bzf_pkg::OP_SRL, bzf_pkg::OP_SWAP: begin
        case (cmd)
          bzf_pkg::OP_RLC: begin r8 = {v[6:0], v[7]}; co = v[7]; end
          bzf_pkg::OP_RRC: begin r8 = {v[0], v[7:1]}; co = v[0]; end
          bzf_pkg::OP_RL:  begin r8 = {v[6:0], cy};   co = v[7]; end
          bzf_pkg::OP_RR:  begin r8 = {cy, v[7:1]};   co = v[0]; end
          bzf_pkg::OP_SLA: begin r8 = {v[6:0], 1'b0}; co = v[7]; end
          bzf_pkg::OP_SRA: begin r8 = {v[7], v[7:1]}; co = v[0]; end
          bzf_pkg::OP_SRL: begin r8 = {1'b0, v[7:1]}; co = v[0]; end
          default:         begin r8 = {v[3:0], v[7:4]}; co = 1'b0; end
        endcase
        val = {8'd0, r8};
        f = '0; f.z = (r8 == 8'd0); f.c = co;
      end
      bzf_pkg::OP_BIT: begin
        f.z = ~v[bi]; f.n = 1'b0; f.h = 1'b1;
      end
      bzf_pkg::OP_SET: val = {8'd0, v | (8'd1 << bi)};
      bzf_pkg::OP_RES: val = {8'd0, v & ~(8'd1 << bi)};
      bzf_pkg::OP_ADD_HL: begin
        s17 = {1'b0, base} + {1'b0, opw};
        h12 = {1'b0, base[11:0]} + {1'b0, opw[11:0]};
        val = s17[15:0];
        f.n = 1'b0; f.h = h12[12]; f.c = s17[16];
      end
      bzf_pkg::OP_ADD_SP: begin
        // signed 8-bit offset; H/C from the unsigned low-byte add
        val = base + {{8{v[7]}}, v};
        h4  = {1'b0, base[3:0]} + {1'b0, v[3:0]};
        c8  = {1'b0, base[7:0]} + {1'b0, v};
        f = '0; f.h = h4[4]; f.c = c8[8];
      end
      bzf_pkg::OP_LOAD_A:     a = v;
      bzf_pkg::OP_LOAD_FLAGS: f = bzf_pkg::flags_t'(opw[3:0]);
      default: ;
    endcase
    acc_shadow        = a;
    flags_shadow      = f;
    r.value_out       = val;
    r.accumulator_out = a;
    r.flags_out       = f;
    return r;
  endfunction

  // Directed stimulus. Rows with has_want set carry a hand-written expectation.
  typedef struct packed {
    logic [5:0]  cmd;
    logic [15:0] opw;
    logic [2:0]  bi;
    logic [15:0] base;
    logic        has_want;
    logic [27:0] want;   // value_out, accumulator_out, flags_out (Z N H C)
  } op_row_t;

  localparam int unsigned N_ROWS = 40;
  op_row_t op_table [N_ROWS] = '{
    // reset state seen through a no-op at the top of the unused range
    '{CMD_UNUSED_HI,          16'hffff, 3'd7, 16'hffff, 1'b1, {16'h0000, 8'h01, 4'hb}},
    // flag load uses only the low nibble
    '{bzf_pkg::OP_LOAD_FLAGS, 16'hfff0, 3'd0, 16'h0000, 1'b1, {16'h0000, 8'h01, 4'h0}},
    '{bzf_pkg::OP_LOAD_A,     16'hffff, 3'd7, 16'hffff, 1'b1, {16'h0000, 8'hff, 4'h0}},
    '{CMD_UNUSED_LO,          16'h0000, 3'd0, 16'h0000, 1'b1, {16'h0000, 8'hff, 4'h0}},
    // 0xff + 1 wraps to zero with half and full carry
    '{bzf_pkg::OP_ADD,        16'h0001, 3'd0, 16'h0000, 1'b1, {16'h0000, 8'h00, 4'hb}},
    '{bzf_pkg::OP_ADC,        16'h00ff, 3'd0, 16'h0000, 1'b0, '0},
    '{bzf_pkg::OP_SUB,        16'h0001, 3'd0, 16'h0000, 1'b0, '0},
    '{bzf_pkg::OP_SBC,        16'h00ff, 3'd0, 16'h0000, 1'b0, '0},
    '{bzf_pkg::OP_AND,        16'h00f0, 3'd0, 16'h0000, 1'b0, '0},
    '{bzf_pkg::OP_XOR,        16'h00ff, 3'd0, 16'h0000, 1'b0, '0},
    '{bzf_pkg::OP_OR,         16'h0000, 3'd0, 16'h0000, 1'b0, '0},
    '{bzf_pkg::OP_CP,         16'h0080, 3'd0, 16'h0000, 1'b0, '0},
    '{bzf_pkg::OP_LOAD_A,     16'h0045, 3'd0, 16'h0000, 1'b0, '0},
    // BCD adjust after an add, then after a subtract
    '{bzf_pkg::OP_ADD,        16'h0038, 3'd0, 16'h0000, 1'b0, '0},
    '{bzf_pkg::OP_DAA,        16'h0000, 3'd0, 16'h0000, 1'b0, '0},
    '{bzf_pkg::OP_SUB,        16'h0009, 3'd0, 16'h0000, 1'b0, '0},
    '{bzf_pkg::OP_DAA,        16'h0000, 3'd0, 16'h0000, 1'b0, '0},
    '{bzf_pkg::OP_CPL,        16'h0000, 3'd0, 16'h0000, 1'b0, '0},
    '{bzf_pkg::OP_SCF,        16'h0000, 3'd0, 16'h0000, 1'b0, '0},
    '{bzf_pkg::OP_CCF,        16'h0000, 3'd0, 16'h0000, 1'b0, '0},
    '{bzf_pkg::OP_RLCA,       16'h0000, 3'd0, 16'h0000, 1'b0, '0},
    '{bzf_pkg::OP_RRCA,       16'h0000, 3'd0, 16'h0000, 1'b0, '0},
    '{bzf_pkg::OP_RLA,        16'h0000, 3'd0, 16'h0000, 1'b0, '0},
    '{bzf_pkg::OP_RRA,        16'h0000, 3'd0, 16'h0000, 1'b0, '0},
    '{bzf_pkg::OP_INC,        16'h00ff, 3'd0, 16'h0000, 1'b0, '0},
    '{bzf_pkg::OP_DEC,        16'h0000, 3'd0, 16'h0000, 1'b0, '0},
    '{bzf_pkg::OP_RLC,        16'h0080, 3'd0, 16'h0000, 1'b0, '0},
    '{bzf_pkg::OP_RRC,        16'h0001, 3'd0, 16'h0000, 1'b0, '0},
    '{bzf_pkg::OP_RL,         16'h0080, 3'd0, 16'h0000, 1'b0, '0},
    '{bzf_pkg::OP_RR,         16'h0001, 3'd0, 16'h0000, 1'b0, '0},
    '{bzf_pkg::OP_SLA,        16'h0080, 3'd0, 16'h0000, 1'b0, '0},
    '{bzf_pkg::OP_SRA,        16'h0081, 3'd0, 16'h0000, 1'b0, '0},
    '{bzf_pkg::OP_SRL,        16'h0001, 3'd0, 16'h0000, 1'b0, '0},
    '{bzf_pkg::OP_SWAP,       16'h00f0, 3'd0, 16'h0000, 1'b0, '0},
    '{bzf_pkg::OP_BIT,        16'h007f, 3'd7, 16'h0000, 1'b0, '0},
    '{bzf_pkg::OP_SET,        16'h0000, 3'd0, 16'h0000, 1'b0, '0},
    '{bzf_pkg::OP_RES,        16'hffff, 3'd7, 16'h0000, 1'b0, '0},
    '{bzf_pkg::OP_ADD_HL,     16'hffff, 3'd0, 16'h0001, 1'b0, '0},
    // negative and positive stack offsets
    '{bzf_pkg::OP_ADD_SP,     16'h0080, 3'd0, 16'h00ff, 1'b0, '0},
    '{bzf_pkg::OP_ADD_SP,     16'h007f, 3'd0, 16'hff80, 1'b0, '0}
  };

  // Send one operation; the expectation is queued on the accepting edge.
  task automatic issue_op(input logic [5:0] cmd, input logic [15:0] opw, input logic [2:0] bi,
                          input logic [15:0] base, input logic has_want,
                          input bzf_pkg::alu_rsp_t want);
    bzf_pkg::alu_rsp_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tuser_i  <= cmd;
    s_tdata_i  <= {5'd0, base, bi, opw};
    do @(posedge clk_i); while (!s_tready_o);
    predicted = compute_alu_result(cmd, opw, bi, base);
    pending_results.push_back(has_want ? want : predicted);
    ops_issued++;
    opcodes_hit[cmd] = 1'b1;
    if (cmd > bzf_pkg::OP_LOAD_FLAGS) unused_issued++;
  endtask

  // Hold the sender off until every outstanding result has been checked.
  task automatic drain_results();
    s_tvalid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Result monitor and tready generator; values sampled are the pre-edge ones.
  always @(posedge clk_i) begin
    bzf_pkg::alu_rsp_t               want;
    logic [bzf_pkg::OUT_TDATA_W-1:0] got;
    if (rst_ni && m_tvalid_o && m_tready_i) begin
      got = m_tdata_o;
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result transaction with nothing outstanding: tdata=%h", got);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (got[15:0] !== want.value_out) begin
          $error("value_out: expected %h, got %h", want.value_out, got[15:0]);
          error_count++;
        end
        if (got[23:16] !== want.accumulator_out) begin
          $error("accumulator_out: expected %h, got %h", want.accumulator_out, got[23:16]);
          error_count++;
        end
        if (got[27:24] !== want.flags_out) begin
          $error("flags_out: expected %b, got %b", want.flags_out, got[27:24]);
          error_count++;
        end
        if (got[31:28] !== 4'd0) begin
          $error("tdata pad: expected %h, got %h", 4'd0, got[31:28]);
          error_count++;
        end
      end
    end
    m_tready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_CAP) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    logic [5:0]  cmd;
    int unsigned n_hit;
    send_idle_pct = 11;
    recv_idle_pct = 81;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (op_table[i]) begin
      issue_op(op_table[i].cmd, op_table[i].opw, op_table[i].bi, op_table[i].base,
               op_table[i].has_want, bzf_pkg::alu_rsp_t'(op_table[i].want));
    end

    // random operations; unused opcodes in about one transaction in ten
    for (int unsigned i = 0; i < RANDOM_OPS; i++) begin
      if (i == PHASE_LEN) begin
        drain_results();
        send_idle_pct = 81;
        recv_idle_pct = 11;
      end else if (i == 2 * PHASE_LEN) begin
        drain_results();
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if ($urandom_range(9) == 0) cmd = 6'($urandom_range(CMD_UNUSED_HI, CMD_UNUSED_LO));
      else cmd = 6'($urandom_range(bzf_pkg::OP_LOAD_FLAGS, bzf_pkg::OP_ADD));
      issue_op(cmd, 16'($urandom_range(16'hffff)), 3'($urandom_range(7)),
               16'($urandom_range(16'hffff)), 1'b0, '0);
    end

    drain_results();
    repeat (DRAIN_CYC) @(posedge clk_i);

    n_hit = 0;
    for (int k = 0; k < 64; k++) begin
      if (opcodes_hit[k]) n_hit++;
    end
    $display("%0d ALU transactions sent (%0d with unused opcodes), %0d results compared",
             ops_issued, unused_issued, results_seen);
    $display("%0d distinct opcodes exercised under three sender/receiver stall profiles",
             n_hit);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
